[hdl/ssed_pkg.sv]
package ssed_pkg;

    // Pixel and value widths
    localparam int VAL_W     = 9;
    localparam int PIX_W     = 3 * VAL_W;
    localparam int WIN_N     = 9;
    localparam int WIN_MID   = 4;

    // Geometry
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int MAX_HEIGHT    = 2048;
    localparam int ROW_W         = 11;
    localparam int GEO_W         = 13;
    localparam int GEO_MIN       = 4;

    // Register widths
    localparam int FRAME_W  = 12;
    localparam int BAND_W   = 8;
    localparam int COUNT_W  = 10;
    localparam int SHIFT_W  = 2;
    localparam int COORD_W  = 14;
    localparam int RESP_W   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_ZERO_BAND     = 3'd2,
        CFG_CONTRAST_MIN  = 3'd3,
        CFG_MAX_KEYPOINTS = 3'd4,
        CFG_SCALE_SHIFT   = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH   = 12'd320;
    localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT  = 12'd240;
    localparam logic [BAND_W-1:0]  RST_ZERO_BAND     = 8'd2;
    localparam logic [BAND_W-1:0]  RST_CONTRAST_MIN  = 8'd5;
    localparam logic [COUNT_W-1:0] RST_MAX_KEYPOINTS = 10'd1000;
    localparam logic [SHIFT_W-1:0] RST_SCALE_SHIFT   = 2'd0;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // Output queue
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PW    = 2;
    localparam int OUTQ_CW    = 2;

    typedef struct packed {
        logic                  pass;
        logic                  is_max;
        logic [RESP_W-1:0]     response;
    } t_test;

    typedef struct packed {
        logic                  is_max;
        logic [COUNT_W-1:0]    index;
        logic [RESP_W-1:0]     response;
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    col;
    } t_key;

endpackage

[hdl/ssed_ram.sv]
module ssed_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ssed_test.sv]
module ssed_test (
    input  logic [ssed_pkg::PIX_W-1:0]  i_win [ssed_pkg::WIN_N],
    input  logic [ssed_pkg::BAND_W-1:0] i_zero_band,
    input  logic [ssed_pkg::BAND_W-1:0] i_contrast_min,
    output ssed_pkg::t_test             o_res
);

    localparam int VW = ssed_pkg::VAL_W;

    logic signed [VW-1:0] v;
    logic signed [VW:0]   v_ext;
    logic [VW-1:0]        mag;
    logic                 want_max;
    logic [3*ssed_pkg::WIN_N-1:0] gt;
    logic [3*ssed_pkg::WIN_N-1:0] lt;
    logic                 enough;

    // Centre value of the tested layer and its magnitude
    assign v        = signed'(i_win[ssed_pkg::WIN_MID][2*VW-1:VW]);
    assign v_ext    = (VW+1)'(v);
    assign mag      = v[VW-1] ? VW'(-v_ext) : VW'(v_ext);
    assign want_max = (v > 0);

    // Compare the centre against every neighbour of all three layers
    always_comb begin
        gt = '1;
        lt = '1;
        for (int k = 0; k < ssed_pkg::WIN_N; k++) begin
            for (int l = 0; l < 3; l++) begin
                if (!(l == 1 && k == ssed_pkg::WIN_MID)) begin
                    gt[k*3+l] = v > signed'(i_win[k][l*VW +: VW]);
                    lt[k*3+l] = v < signed'(i_win[k][l*VW +: VW]);
                end
            end
        end
    end

    // Magnitude must reach the contrast floor and leave the zero band
    assign enough = (mag >= VW'(i_contrast_min)) && (mag >= VW'(i_zero_band));

    assign o_res.pass     = enough && (want_max ? (&gt) : (&lt));
    assign o_res.is_max   = want_max;
    assign o_res.response = mag[VW-1] ? '1 : mag[ssed_pkg::RESP_W-1:0];

endmodule

[hdl/scale_space_extremum_detector.sv]
// Scale-space extremum detector. Takes one pixel per beat in raster order; each
// beat carries the lower, centre and upper difference-of-Gaussian values of that
// pixel, and tuser marks the first pixel of a frame. A centre pixel is tested once
// the pixel one row and one column past it arrives, against its 26 neighbours in
// a 3x3x3 window built from two line stores and per-row column registers. A
// passing pixel leaves as one keypoint beat (column, row, response, index; tuser
// holds 1 for a maximum, 0 for a minimum), until max_keypoints per frame is
// reached. The block accepts one pixel every cycle while ready is high: the line
// store read is registered, the test runs on the registered test stage, and a
// three-entry output queue absorbs results, so input ready drops only when that
// queue backs up. Line stores need no clearing pass; configuration writes are
// taken at any cycle and belong between frames.
module scale_space_extremum_detector #(
    parameter int MAX_WIDTH = ssed_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [8:0] lower_scale_value, [17:9] centre_scale_value, [26:18] upper_scale_value
    input  logic [ssed_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [0] frame_start
    input  logic [0:0]                         i_s_tuser,
    // keypoint stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [13:0] key_col, [27:14] key_row, [35:28] response, [45:36] keypoint_index
    output logic [ssed_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // [0] is_maximum
    output logic [0:0]                         o_m_tuser,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssed_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ssed_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int PW  = ssed_pkg::PIX_W;
    localparam int GW  = ssed_pkg::GEO_W;
    localparam int RW  = ssed_pkg::ROW_W;
    localparam int CNW = ssed_pkg::COUNT_W;

    // Configuration registers
    logic [ssed_pkg::FRAME_W-1:0] r_frame_width, r_frame_height;
    logic [ssed_pkg::BAND_W-1:0]  r_zero_band, r_contrast_min;
    logic [CNW-1:0]               r_max_kp;
    logic [ssed_pkg::SHIFT_W-1:0] r_scale_shift;

    // Position counters
    logic [XW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [XW-1:0]  cur_x;
    logic [RW-1:0]  cur_y;
    logic [XW-1:0]  n_col;
    logic [RW-1:0]  n_row;
    logic [GW-1:0]  w_clamp, h_clamp;

    // Test stage
    logic           r_s1_valid;
    logic           r_s1_fs;
    logic [PW-1:0]  r_s1_pix;
    logic [XW-1:0]  r_s1_x;
    logic [RW-1:0]  r_s1_y;
    logic           r_byp_hit;
    logic [PW-1:0]  r_byp_older, r_byp_newer;
    logic [PW-1:0]  ram_older_q, ram_newer_q;
    logic [PW-1:0]  above, mid;
    logic [PW-1:0]  r_win [ssed_pkg::WIN_N];
    logic [PW-1:0]  n_win [ssed_pkg::WIN_N];
    logic [CNW-1:0] r_emit;
    logic [CNW-1:0] emit_cur;
    logic           interior;
    logic           push;
    ssed_pkg::t_test test_res;
    ssed_pkg::t_key  key;

    // Output queue
    ssed_pkg::t_key              r_q [ssed_pkg::OUTQ_DEPTH];
    logic [ssed_pkg::OUTQ_PW-1:0] r_wr, r_rd;
    logic [ssed_pkg::OUTQ_CW-1:0] r_cnt;
    logic                        pop;
    logic                        s_acc;
    ssed_pkg::t_key              head;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ssed_pkg::RST_FRAME_WIDTH;
            r_frame_height <= ssed_pkg::RST_FRAME_HEIGHT;
            r_zero_band    <= ssed_pkg::RST_ZERO_BAND;
            r_contrast_min <= ssed_pkg::RST_CONTRAST_MIN;
            r_max_kp       <= ssed_pkg::RST_MAX_KEYPOINTS;
            r_scale_shift  <= ssed_pkg::RST_SCALE_SHIFT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssed_pkg::CFG_FRAME_WIDTH:   r_frame_width  <= i_cfg_data;
                ssed_pkg::CFG_FRAME_HEIGHT:  r_frame_height <= i_cfg_data;
                ssed_pkg::CFG_ZERO_BAND:     r_zero_band    <= i_cfg_data[ssed_pkg::BAND_W-1:0];
                ssed_pkg::CFG_CONTRAST_MIN:  r_contrast_min <= i_cfg_data[ssed_pkg::BAND_W-1:0];
                ssed_pkg::CFG_MAX_KEYPOINTS: r_max_kp       <= i_cfg_data[CNW-1:0];
                ssed_pkg::CFG_SCALE_SHIFT:   r_scale_shift  <= i_cfg_data[ssed_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp geometry to the supported range
    always_comb begin
        if (GW'(r_frame_width) < GW'(ssed_pkg::GEO_MIN)) begin
            w_clamp = GW'(ssed_pkg::GEO_MIN);
        end else if (GW'(r_frame_width) > GW'(MAX_WIDTH)) begin
            w_clamp = GW'(MAX_WIDTH);
        end else begin
            w_clamp = GW'(r_frame_width);
        end
        if (GW'(r_frame_height) < GW'(ssed_pkg::GEO_MIN)) begin
            h_clamp = GW'(ssed_pkg::GEO_MIN);
        end else if (GW'(r_frame_height) > GW'(ssed_pkg::MAX_HEIGHT)) begin
            h_clamp = GW'(ssed_pkg::MAX_HEIGHT);
        end else begin
            h_clamp = GW'(r_frame_height);
        end
    end

    // Accept while the queue has room for what is in flight
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (3'(r_cnt) + 3'(r_s1_valid)) < 3'(ssed_pkg::OUTQ_DEPTH);

    // Current position and next position
    always_comb begin
        cur_x = i_s_tuser[0] ? '0 : r_col;
        cur_y = i_s_tuser[0] ? '0 : r_row;
        if (GW'(cur_x) + GW'(1) >= w_clamp) begin
            n_col = '0;
            n_row = (GW'(cur_y) + GW'(1) >= h_clamp) ? '0 : cur_y + RW'(1);
        end else begin
            n_col = cur_x + XW'(1);
            n_row = cur_y;
        end
    end

    // Advance position and load the test stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= s_acc;
            if (s_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_pix    <= i_s_tdata[PW-1:0];
            r_s1_x      <= cur_x;
            r_s1_y      <= cur_y;
            r_s1_fs     <= i_s_tuser[0];
            // Forward the line store write that lands on the same column this edge
            r_byp_hit   <= r_s1_valid && (r_s1_x == cur_x);
            r_byp_older <= mid;
            r_byp_newer <= r_s1_pix;
        end
    end

    // Line stores for rows y-2 and y-1
    ssed_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_x),
        .i_wdata (mid),
        .i_re    (s_acc),
        .i_raddr (cur_x),
        .o_rdata (ram_older_q)
    );

    ssed_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_x),
        .i_wdata (r_s1_pix),
        .i_re    (s_acc),
        .i_raddr (cur_x),
        .o_rdata (ram_newer_q)
    );

    assign above = r_byp_hit ? r_byp_older : ram_older_q;
    assign mid   = r_byp_hit ? r_byp_newer : ram_newer_q;

    // Shift the window one column and bring in the new column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3+1];
            n_win[r*3 + 1] = r_win[r*3+2];
        end
        n_win[2] = above;
        n_win[5] = mid;
        n_win[8] = r_s1_pix;
    end

    ssed_test u_test (
        .i_win          (n_win),
        .i_zero_band    (r_zero_band),
        .i_contrast_min (r_contrast_min),
        .o_res          (test_res)
    );

    // Decide whether this centre becomes a keypoint
    assign emit_cur = r_s1_fs ? '0 : r_emit;
    assign interior = (r_s1_x >= XW'(2)) && (GW'(r_s1_x) < w_clamp)
                   && (r_s1_y >= RW'(2)) && (GW'(r_s1_y) < h_clamp);
    assign push     = r_s1_valid && interior && test_res.pass && (emit_cur < r_max_kp);

    assign key.col      = ssed_pkg::COORD_W'((ssed_pkg::COORD_W'(r_s1_x) - 14'd1) << r_scale_shift);
    assign key.row      = ssed_pkg::COORD_W'((ssed_pkg::COORD_W'(r_s1_y) - 14'd1) << r_scale_shift);
    assign key.response = test_res.response;
    assign key.is_max   = test_res.is_max;
    assign key.index    = emit_cur;

    // Hold window and keypoint count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ssed_pkg::WIN_N; k++) begin
                r_win[k] <= '0;
            end
            r_emit <= '0;
        end else if (r_s1_valid) begin
            r_win  <= n_win;
            r_emit <= push ? emit_cur + CNW'(1) : emit_cur;
        end
    end

    // Output queue
    assign pop  = o_m_tvalid && i_m_tready;
    assign head = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == ssed_pkg::OUTQ_PW'(ssed_pkg::OUTQ_DEPTH - 1)) ? '0 : r_wr + 2'd1;
            end
            if (pop) begin
                r_rd <= (r_rd == ssed_pkg::OUTQ_PW'(ssed_pkg::OUTQ_DEPTH - 1)) ? '0 : r_rd + 2'd1;
            end
            r_cnt <= r_cnt + ssed_pkg::OUTQ_CW'(push) - ssed_pkg::OUTQ_CW'(pop);
        end
    end

    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = {2'b00, head.index, head.response, head.row, head.col};
    assign o_m_tuser  = head.is_max;

    // Queue never overflows
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ssed_pkg::OUTQ_CW'(ssed_pkg::OUTQ_DEPTH))
        else $error("output queue overflow");

    // A keypoint is only produced below the per-frame limit
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> key.index < r_max_kp)
        else $error("keypoint emitted past limit");

    // Response of a keypoint reaches the contrast floor
    a_contrast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> key.response >= r_contrast_min)
        else $error("keypoint below contrast floor");

    // The column counter stays inside the clamped row width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> GW'(r_col) < $past(w_clamp))
        else $error("column counter out of range");

endmodule

[tb/sv/scale_space_extremum_detector_test.sv]
`timescale 1ns / 100ps

module scale_space_extremum_detector_test;

    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned KEY_BITS     =
        2 * ssed_pkg::COORD_W + ssed_pkg::RESP_W + ssed_pkg::COUNT_W;

    // Indexes past the register list; the block must ignore them
    localparam logic [ssed_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [ssed_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum int unsigned {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_mode;

    // Mirror of the detector: geometry, thresholds, line stores and the 3x3x3 window,
    // plus the keypoints still owed by the block
    class t_keypoint_book;
        logic [ssed_pkg::FRAME_W-1:0] frame_width;
        logic [ssed_pkg::FRAME_W-1:0] frame_height;
        logic [ssed_pkg::BAND_W-1:0]  zero_band;
        logic [ssed_pkg::BAND_W-1:0]  contrast_min;
        logic [ssed_pkg::COUNT_W-1:0] max_keys;
        logic [ssed_pkg::SHIFT_W-1:0] scale_shift;
        logic [ssed_pkg::PIX_W-1:0]   older_row [ssed_pkg::DEF_MAX_WIDTH];
        logic [ssed_pkg::PIX_W-1:0]   newer_row [ssed_pkg::DEF_MAX_WIDTH];
        logic [ssed_pkg::PIX_W-1:0]   window [ssed_pkg::WIN_N];
        int unsigned                  col_pos;
        int unsigned                  row_pos;
        logic [ssed_pkg::COUNT_W-1:0] emitted;
        ssed_pkg::t_key               pending_keys [$];
        int                           errors;

        function new();
            frame_width  = ssed_pkg::RST_FRAME_WIDTH;
            frame_height = ssed_pkg::RST_FRAME_HEIGHT;
            zero_band    = ssed_pkg::RST_ZERO_BAND;
            contrast_min = ssed_pkg::RST_CONTRAST_MIN;
            max_keys     = ssed_pkg::RST_MAX_KEYPOINTS;
            scale_shift  = ssed_pkg::RST_SCALE_SHIFT;
            foreach (older_row[i]) begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            col_pos = 0;
            row_pos = 0;
            emitted = '0;
            errors  = 0;
        endfunction

        static function int unsigned fit(int unsigned v, int unsigned hi);
            return (v < ssed_pkg::GEO_MIN) ? ssed_pkg::GEO_MIN : ((v > hi) ? hi : v);
        endfunction

        function int unsigned row_len();
            return fit(frame_width, ssed_pkg::DEF_MAX_WIDTH);
        endfunction

        function int unsigned frame_rows();
            return fit(frame_height, ssed_pkg::MAX_HEIGHT);
        endfunction

        static function int layer_value(logic [ssed_pkg::PIX_W-1:0] p, int unsigned layer);
            logic signed [ssed_pkg::VAL_W-1:0] s;
            s = p[ssed_pkg::VAL_W*layer +: ssed_pkg::VAL_W];
            return int'(s);
        endfunction

        function void note_config(logic [ssed_pkg::CFG_IDX_W-1:0] idx,
                                  logic [ssed_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                ssed_pkg::CFG_FRAME_WIDTH:   frame_width  = d;
                ssed_pkg::CFG_FRAME_HEIGHT:  frame_height = d;
                ssed_pkg::CFG_ZERO_BAND:     zero_band    = d[ssed_pkg::BAND_W-1:0];
                ssed_pkg::CFG_CONTRAST_MIN:  contrast_min = d[ssed_pkg::BAND_W-1:0];
                ssed_pkg::CFG_MAX_KEYPOINTS: max_keys     = d[ssed_pkg::COUNT_W-1:0];
                ssed_pkg::CFG_SCALE_SHIFT:   scale_shift  = d[ssed_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the raster by one pixel and queue the keypoint it completes, if any
        function void take_pixel(logic [ssed_pkg::PIX_W-1:0] pix, logic frame_start);
            int unsigned                w, h, x, y;
            logic [ssed_pkg::PIX_W-1:0] above, mid;
            int                         v, mag, nb;
            bit                         want_max, extremum;
            ssed_pkg::t_key             k;
            if (frame_start) begin
                col_pos = 0;
                row_pos = 0;
                emitted = '0;
            end
            w = row_len();
            h = frame_rows();
            x = col_pos % ssed_pkg::DEF_MAX_WIDTH;
            y = row_pos;

            // Shift the line stores and the window columns
            above = older_row[x];
            mid   = newer_row[x];
            older_row[x] = mid;
            newer_row[x] = pix;
            for (int r = 0; r < 3; r++) begin
                window[r*3]   = window[r*3+1];
                window[r*3+1] = window[r*3+2];
            end
            window[2] = above;
            window[5] = mid;
            window[8] = pix;

            // Wrap column, then row
            if (x + 1 >= w) begin
                col_pos = 0;
                row_pos = (y + 1 >= h) ? 0 : y + 1;
            end else begin
                col_pos = x + 1;
            end

            // Test the centre one row and one column back; borders are skipped
            if (x < 2 || x >= w || y < 2 || y >= h) return;
            v   = layer_value(window[ssed_pkg::WIN_MID], 1);
            mag = (v < 0) ? -v : v;
            if (mag < int'(contrast_min)) return;
            if (v > -int'(zero_band) && v < int'(zero_band)) return;
            want_max = v > 0;
            extremum = 1'b1;
            for (int layer = 0; layer < 3; layer++) begin
                for (int j = 0; j < ssed_pkg::WIN_N; j++) begin
                    if (layer == 1 && j == ssed_pkg::WIN_MID) continue;
                    nb = layer_value(window[j], layer);
                    if (want_max ? (nb >= v) : (nb <= v)) extremum = 1'b0;
                end
            end
            if (!extremum || emitted >= max_keys) return;

            k.col      = ssed_pkg::COORD_W'((x - 1) << scale_shift);
            k.row      = ssed_pkg::COORD_W'((y - 1) << scale_shift);
            k.response = (mag > 255) ? 8'd255 : ssed_pkg::RESP_W'(mag);
            k.is_max   = want_max;
            k.index    = emitted;
            emitted    = emitted + 1'b1;
            pending_keys.push_back(k);
        endfunction

        function bit field_ok(string name, int unsigned want, int unsigned got);
            if (want == got) return 1'b1;
            $display("%0t: keypoint %s differs: expected %0d, actual %0d",
                     $time, name, want, got);
            return 1'b0;
        endfunction

        // Compare one keypoint beat against the oldest owed keypoint
        function void match_key(ssed_pkg::t_key got);
            ssed_pkg::t_key want;
            bit             ok;
            if (pending_keys.size() == 0) begin
                errors++;
                $display("%0t: keypoint beat with none expected: %s col %0d row %0d",
                         $time, "expected none, actual", got.col, got.row);
                return;
            end
            want = pending_keys.pop_front();
            ok = field_ok("key_col", want.col, got.col);
            ok = field_ok("key_row", want.row, got.row) & ok;
            ok = field_ok("response", want.response, got.response) & ok;
            ok = field_ok("is_maximum", want.is_max, got.is_max) & ok;
            ok = field_ok("keypoint_index", want.index, got.index) & ok;
            if (!ok) errors++;
        endfunction
    endclass

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_s_tvalid  = 1'b0;
    logic [ssed_pkg::S_TDATA_W-1:0]    i_s_tdata   = '0;
    logic [0:0]                        i_s_tuser   = '0;
    logic                              i_m_tready  = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic [ssed_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [ssed_pkg::CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                              o_s_tready;
    logic                              o_m_tvalid;
    logic [ssed_pkg::M_TDATA_W-1:0]    o_m_tdata;
    logic [0:0]                        o_m_tuser;
    logic                              o_cfg_ready;

    t_keypoint_book book;
    int unsigned    burst_left   = 0;
    int unsigned    quiet_cycles = 0;

    scale_space_extremum_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Check every keypoint beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            book.match_key(ssed_pkg::t_key'({o_m_tuser[0], o_m_tdata[KEY_BITS-1:0]}));
    end

    // End the run when no beat moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Keypoint sink: switch between open, coin-flip, sparse and periodic stalls
    initial begin : sink_pattern
        t_sink_mode  mode;
        int unsigned span;
        for (;;) begin
            mode = t_sink_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 300);
            for (int unsigned tick = 0; tick < span; tick++) begin
                @(posedge i_clk);
                case (mode)
                    SINK_OPEN:   i_m_tready <= 1'b1;
                    SINK_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: i_m_tready <= ($urandom_range(0, 7) == 0);
                    default:     i_m_tready <= ((tick % 9) >= 6);
                endcase
            end
        end
    end

    task automatic write_reg(logic [ssed_pkg::CFG_IDX_W-1:0] idx,
                             logic [ssed_pkg::CFG_DATA_W-1:0] d);
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.note_config(idx, d);
    endtask

    // Wait for the block to go idle, then load a full register set; spare upper bits
    // of the narrow registers carry noise
    task automatic set_config(int unsigned w, int unsigned h, int unsigned zb,
                              int unsigned cm, int unsigned kmax, int unsigned shift);
        logic [ssed_pkg::CFG_DATA_W-1:0] junk;
        while (book.pending_keys.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(ssed_pkg::CFG_FRAME_WIDTH, ssed_pkg::CFG_DATA_W'(w));
        write_reg(ssed_pkg::CFG_FRAME_HEIGHT, ssed_pkg::CFG_DATA_W'(h));
        junk = ssed_pkg::CFG_DATA_W'($urandom);
        write_reg(ssed_pkg::CFG_ZERO_BAND,
                  {junk[ssed_pkg::CFG_DATA_W-1:ssed_pkg::BAND_W], ssed_pkg::BAND_W'(zb)});
        junk = ssed_pkg::CFG_DATA_W'($urandom);
        write_reg(ssed_pkg::CFG_CONTRAST_MIN,
                  {junk[ssed_pkg::CFG_DATA_W-1:ssed_pkg::BAND_W], ssed_pkg::BAND_W'(cm)});
        junk = ssed_pkg::CFG_DATA_W'($urandom);
        write_reg(ssed_pkg::CFG_MAX_KEYPOINTS,
                  {junk[ssed_pkg::CFG_DATA_W-1:ssed_pkg::COUNT_W],
                   ssed_pkg::COUNT_W'(kmax)});
        junk = ssed_pkg::CFG_DATA_W'($urandom);
        write_reg(ssed_pkg::CFG_SCALE_SHIFT,
                  {junk[ssed_pkg::CFG_DATA_W-1:ssed_pkg::SHIFT_W],
                   ssed_pkg::SHIFT_W'(shift)});
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  ssed_pkg::CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Send one pixel beat; open a gap first when the current burst is used up
    task automatic offer_pixel(logic [ssed_pkg::PIX_W-1:0] pix, logic fs);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tdata  <= ssed_pkg::S_TDATA_W'(pix);
        i_s_tuser  <= fs;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        book.take_pixel(pix, fs);
    endtask

    // Low-level noise with planted centre spikes, rare outer-layer spikes and rare
    // fully random pixels
    function automatic logic [ssed_pkg::PIX_W-1:0] draw_pixel();
        logic signed [ssed_pkg::VAL_W-1:0] lower, centre, upper;
        int unsigned pick, mag;
        pick = $urandom_range(0, 99);
        if (pick < 2) return ssed_pkg::PIX_W'($urandom);
        lower  = ssed_pkg::VAL_W'(int'($urandom_range(0, 40)) - 20);
        centre = ssed_pkg::VAL_W'(int'($urandom_range(0, 40)) - 20);
        upper  = ssed_pkg::VAL_W'(int'($urandom_range(0, 40)) - 20);
        if (pick < 12) begin
            mag = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(60, 255);
            if ($urandom_range(0, 1))
                centre = ssed_pkg::VAL_W'(mag);
            else if (mag == 255 && $urandom_range(0, 1))
                centre = ssed_pkg::VAL_W'(-256);
            else
                centre = ssed_pkg::VAL_W'(-int'(mag));
        end else if (pick < 15) begin
            if ($urandom_range(0, 1)) lower = ssed_pkg::VAL_W'($urandom);
            else                      upper = ssed_pkg::VAL_W'($urandom);
        end
        return {upper, centre, lower};
    endfunction

    // Stream frames of the current geometry; most start with frame_start, some rely on
    // the row wrap, and a few restart in the middle of a frame
    task automatic feed_frames(int unsigned count);
        int unsigned pos, frame_len;
        logic        fs;
        frame_len = book.row_len() * book.frame_rows();
        pos = 0;
        for (int unsigned n = 0; n < count; n++) begin
            if (n == 0) begin
                fs = 1'b1;
            end else if ($urandom_range(0, 79) == 0) begin
                fs  = 1'b1;
                pos = 0;
            end else begin
                fs = (pos == 0) && ($urandom_range(0, 3) != 0);
            end
            offer_pixel(draw_pixel(), fs);
            pos = (pos + 1 == frame_len) ? 0 : pos + 1;
        end
        i_s_tvalid <= 1'b0;
    endtask

    // Two 4x4 frames: full-scale maximum beside the deepest minimum, then a zero centre
    task automatic directed_frames();
        logic signed [ssed_pkg::VAL_W-1:0] lower, centre, upper;
        for (int f = 0; f < 2; f++) begin
            for (int y = 0; y < 4; y++) begin
                for (int x = 0; x < 4; x++) begin
                    if (f == 0) begin
                        // extreme outer-layer values sit at the corners of the window
                        lower  = (x == 0 && y == 0) ? ssed_pkg::VAL_W'(-256)
                                                    : ssed_pkg::VAL_W'(0);
                        upper  = (x == 3 && y == 3) ? ssed_pkg::VAL_W'(255)
                                                    : ssed_pkg::VAL_W'(0);
                        centre = (x == 1 && y == 1) ? ssed_pkg::VAL_W'(255)
                               : (x == 2 && y == 2) ? ssed_pkg::VAL_W'(-256)
                                                    : ssed_pkg::VAL_W'(1);
                    end else begin
                        lower  = ssed_pkg::VAL_W'(1);
                        upper  = ssed_pkg::VAL_W'(1);
                        centre = (x == 1 && y == 1) ? ssed_pkg::VAL_W'(0)
                                                    : ssed_pkg::VAL_W'(1);
                    end
                    offer_pixel({upper, centre, lower}, x == 0 && y == 0);
                end
            end
        end
        i_s_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        book = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(4, 4, 0, 0, 1023, 0);
        directed_frames();

        set_config(8, 6, 2, 5, 1000, 1);
        feed_frames(250);
        // both sizes below the minimum, thresholds at full scale
        set_config(0, 0, 255, 255, 1023, 3);
        feed_frames(120);
        // small keypoint limit
        set_config(16, 8, 10, 30, 4, 2);
        feed_frames(300);
        // no keypoints allowed
        set_config(5, 12, 0, 0, 0, 0);
        feed_frames(120);
        // widest row, clamped; stay within the first row
        set_config(4095, 4, 0, 0, 1023, 3);
        feed_frames(200);
        // tallest frame, clamped
        set_config(4, 4095, 3, 7, 1023, 1);
        feed_frames(250);
        set_config(11, 7, 1, 1, 600, 2);
        feed_frames(300);
        repeat (3) begin
            set_config($urandom_range(3, 20), $urandom_range(3, 12), $urandom_range(0, 40),
                       $urandom_range(0, 80),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8)
                                                   : $urandom_range(9, 1023),
                       $urandom_range(0, 3));
            feed_frames(120);
        end

        // Drain owed keypoints, then watch for strays
        while (book.pending_keys.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
